// ===== hw/rtl/sphere_collision_table_assert.svh =====
// Assertion macros shared by the sphere collision table RTL.
// Included by files that carry concurrent assertions.
`ifndef SPHERE_COLLISION_TABLE_ASSERT_SVH
`define SPHERE_COLLISION_TABLE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SCT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define SCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hw/rtl/sct_pkg.sv =====
// Package for the sphere collision table: command and status codes, sizes.
// No dependencies.
`default_nettype none
package sct_pkg;
  localparam int SlotsDefault = 16;
  localparam int CoordBitsDefault = 16;
  localparam int MaxRecords = 16;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;
  localparam logic [1:0] CMD_DETECT = 2'd3;

  localparam logic [2:0] ST_ALLOCATED = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_RELEASED = 3'd2;
  localparam logic [2:0] ST_NOT_USED = 3'd3;
  localparam logic [2:0] ST_UPDATED = 3'd4;
  localparam logic [2:0] ST_RECORD = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  // One result word as it travels from the controller to the output register.
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [15:0] mask;
    logic [4:0]  count;
    logic        last;
  } result_t;
endpackage
`default_nettype wire

// ===== hw/rtl/sct_ram.sv =====
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
`default_nettype none
module sct_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/sct_overlap.sv =====
// Overlap test between two spheres: registered squares, then sums and compare.
// Depends on nothing but its parameters.
`default_nettype none
module sct_overlap #(
  parameter int CoordBits = 16
) (
  input  wire logic                        clk,
  input  wire logic signed [CoordBits-1:0] ax, ay, az, bx, by, bz,
  input  wire logic [15:0]                 ra, rb,
  output logic                             hit
);
  localparam int DW = CoordBits + 1;
  localparam int SW = 2 * DW;
  localparam int TW = SW + 2;

  logic signed [DW-1:0] dx, dy, dz;
  logic [DW-1:0] ux, uy, uz;
  logic [SW-1:0] sx, sy, sz;
  logic [16:0] rs;
  logic [33:0] rsq;

  // Differences are exact in one extra bit; squares only need magnitudes.
  assign dx = DW'(ax) - DW'(bx);
  assign dy = DW'(ay) - DW'(by);
  assign dz = DW'(az) - DW'(bz);
  assign ux = dx[DW-1] ? -dx : dx;
  assign uy = dy[DW-1] ? -dy : dy;
  assign uz = dz[DW-1] ? -dz : dz;
  assign rs = {1'b0, ra} + {1'b0, rb};

  // Register the squares and the squared radius sum.
  always_ff @(posedge clk) begin
    sx <= SW'(ux) * SW'(ux);
    sy <= SW'(uy) * SW'(uy);
    sz <= SW'(uz) * SW'(uz);
    rsq <= 34'(rs) * 34'(rs);
  end

  // Compare the distance with the radius sum in a common width.
  localparam int CW = (TW > 34) ? TW : 34;
  assign hit = (CW'(sx) + CW'(sy) + CW'(sz)) < CW'(rsq);
endmodule
`default_nettype wire

// ===== hw/rtl/sphere_collision_table.sv =====
// Sphere collision table. After reset a clearing pass frees every slot
// before the first word is accepted. An update, or a release or update of a
// slot not in use, takes the accepting cycle, a slot read and a write that
// also loads the result word. Allocate probes the slots in order from slot 0,
// a read and a check per slot. Release adds to the read and write a read and
// a check per list entry searched, then moves the last entry into the hole.
// Detect fetches each listed slot and compares an active one with every
// other entry of the list, then gives the done word.
// Results leave through one output register; a stalled result holds up the
// step that produces the next word. Detect gives several words.
`default_nettype none
`include "sphere_collision_table_assert.svh"
module sphere_collision_table #(
  parameter int SLOTS = sct_pkg::SlotsDefault,
  parameter int COORD_BITS = sct_pkg::CoordBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [3:0]  slot_id,
  input  wire logic [15:0] radius,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic signed [15:0] pos_z,
  input  wire logic        active,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [3:0]       result_slot,
  output logic [15:0]      partner_mask,
  output logic [4:0]       hit_count,
  output logic             last
);
  import sct_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int SW = 16 + 3 * COORD_BITS + 1;

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_RD = 5'd2;
  localparam logic [4:0] S_WR = 5'd3;
  localparam logic [4:0] S_SCAN = 5'd4;
  localparam logic [4:0] S_ACC = 5'd5;
  localparam logic [4:0] S_RLS = 5'd6;
  localparam logic [4:0] S_RLS_CHK = 5'd7;
  localparam logic [4:0] S_RLS_LAST = 5'd8;
  localparam logic [4:0] S_RLS_MOVE = 5'd9;
  localparam logic [4:0] S_LA = 5'd10;
  localparam logic [4:0] S_LAW = 5'd11;
  localparam logic [4:0] S_LAH = 5'd12;
  localparam logic [4:0] S_LB = 5'd13;
  localparam logic [4:0] S_LBW = 5'd14;
  localparam logic [4:0] S_CMP = 5'd15;
  localparam logic [4:0] S_PAIR = 5'd16;
  localparam logic [4:0] S_REC = 5'd17;
  localparam logic [4:0] S_DONE = 5'd18;

  logic [4:0] state;
  logic [1:0] cmd;
  logic [3:0] sid;
  logic [15:0] rad;
  logic signed [COORD_BITS-1:0] px, py, pz;
  logic act;
  logic [AW-1:0] idx;
  logic [CW-1:0] used_count, li, lj;
  logic [AW-1:0] a_slot, b_slot, rel_pos;
  logic b_act;
  logic [SW-1:0] a_word;
  logic [15:0] mask;
  logic any;
  logic [4:0] hits;
  logic [4:0] nrec;
  logic out_full;
  result_t res, res_next;
  logic emit;

  // Slot memory: radius, position and active flag in one word.
  logic sm_we;
  logic [AW-1:0] sm_waddr, sm_raddr;
  logic [SW-1:0] sm_wdata, sm_rdata;
  sct_ram #(.Width(SW), .Depth(SLOTS)) u_slots (
    .clk(clk), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
    .raddr(sm_raddr), .rdata(sm_rdata));

  // Used list memory.
  logic ul_we;
  logic [AW-1:0] ul_waddr, ul_raddr;
  logic [AW-1:0] ul_wdata, ul_rdata;
  sct_ram #(.Width(AW), .Depth(SLOTS)) u_list (
    .clk(clk), .we(ul_we), .waddr(ul_waddr), .wdata(ul_wdata),
    .raddr(ul_raddr), .rdata(ul_rdata));

  // Field views of a slot word.
  logic [15:0] r_rad, a_rad;
  logic signed [COORD_BITS-1:0] r_x, r_y, r_z, a_x, a_y, a_z;
  logic r_act, a_act;
  assign {r_rad, r_x, r_y, r_z, r_act} = sm_rdata;
  assign {a_rad, a_x, a_y, a_z, a_act} = a_word;

  logic hit;
  sct_overlap #(.CoordBits(COORD_BITS)) u_ovl (
    .clk(clk), .ax(a_x), .ay(a_y), .az(a_z), .bx(r_x), .by(r_y), .bz(r_z),
    .ra(a_rad), .rb(r_rad), .hit(hit));

  logic in_acc, out_acc, sid_ok, slot_ok, free_hit, last_probe, rec_cap, rec_go;
  logic b_in_mask;
  logic [AW-1:0] sid_idx;
  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state != S_IDLE);
  assign sid_idx = AW'(sid);
  assign sid_ok = ({28'd0, sid} < 32'(SLOTS));
  assign slot_ok = sid_ok && (r_rad != 16'd0);
  assign free_hit = (r_rad == 16'd0) && (used_count < CW'(SLOTS));
  assign last_probe = (idx == AW'(SLOTS - 1));
  assign rec_cap = (nrec >= 5'(MaxRecords));
  assign rec_go = !any || rec_cap || !out_full;
  assign b_in_mask = (32'(b_slot) < 32'd16);

  // Memory control.
  always_comb begin
    sm_we = 1'b0;
    sm_waddr = idx;
    sm_wdata = '0;
    sm_raddr = idx;
    ul_we = 1'b0;
    ul_waddr = AW'(used_count);
    ul_wdata = idx;
    ul_raddr = li[AW-1:0];
    unique case (state)
      S_CLEAR: sm_we = 1'b1;
      S_RD: sm_raddr = sid_idx;
      S_WR: begin
        sm_raddr = sid_idx;
        sm_waddr = sid_idx;
        if (cmd == CMD_UPDATE) begin
          sm_wdata = {r_rad, px, py, pz, act};
        end else begin
          sm_wdata = {16'd0, r_x, r_y, r_z, 1'b0};
        end
        sm_we = slot_ok && !out_full;
      end
      S_ACC: begin
        // The found slot gets its radius and joins the end of the list.
        sm_wdata = {rad, {(3 * COORD_BITS + 1){1'b0}}};
        sm_we = free_hit && !out_full;
        ul_we = free_hit && !out_full;
      end
      S_RLS_LAST: ul_raddr = AW'(used_count - CW'(1));
      S_RLS_MOVE: begin
        ul_raddr = AW'(used_count - CW'(1));
        ul_we = !out_full;
        ul_waddr = rel_pos;
        ul_wdata = ul_rdata;
      end
      S_LAW: sm_raddr = ul_rdata;
      S_LB: ul_raddr = lj[AW-1:0];
      S_LBW: sm_raddr = ul_rdata;
      default: ;
    endcase
  end

  // Result word produced in the current state, loaded when the register is free.
  always_comb begin
    emit = 1'b0;
    res_next = '0;
    unique case (state)
      S_WR: if (!out_full && !(slot_ok && cmd == CMD_RELEASE)) begin
        emit = 1'b1;
        res_next.status = slot_ok ? ST_UPDATED : ST_NOT_USED;
        res_next.slot = sid;
        res_next.last = 1'b1;
      end
      S_ACC: if (!out_full && (free_hit || last_probe)) begin
        emit = 1'b1;
        res_next.status = free_hit ? ST_ALLOCATED : ST_FULL;
        res_next.slot = free_hit ? 4'(idx) : 4'd0;
        res_next.last = 1'b1;
      end
      S_RLS_MOVE: if (!out_full) begin
        emit = 1'b1;
        res_next.status = ST_RELEASED;
        res_next.slot = sid;
        res_next.last = 1'b1;
      end
      S_REC: if (any && !rec_cap && !out_full) begin
        emit = 1'b1;
        res_next.status = ST_RECORD;
        res_next.slot = 4'(a_slot);
        res_next.mask = mask;
      end
      S_DONE: if (!out_full) begin
        emit = 1'b1;
        res_next.status = ST_DONE;
        res_next.count = hits;
        res_next.last = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      used_count <= '0;
      li <= '0;
      lj <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          idx <= idx + AW'(1);
          if (idx == AW'(SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_acc) begin
          cmd <= command;
          sid <= slot_id;
          rad <= (radius == 16'd0) ? 16'd1 : radius;
          px <= COORD_BITS'(pos_x);
          py <= COORD_BITS'(pos_y);
          pz <= COORD_BITS'(pos_z);
          act <= active;
          idx <= '0;
          li <= '0;
          lj <= '0;
          hits <= '0;
          nrec <= '0;
          unique case (command)
            CMD_ALLOC: state <= S_SCAN;
            CMD_DETECT: state <= (used_count == '0) ? S_DONE : S_LA;
            default: state <= S_RD;
          endcase
        end
        S_RD: state <= S_WR;
        S_WR: if (!out_full) begin
          state <= (slot_ok && cmd == CMD_RELEASE) ? S_RLS : S_IDLE;
        end
        S_SCAN: state <= S_ACC;
        S_ACC: begin
          // Free-slot search: one slot read per pass through S_SCAN and S_ACC.
          if (free_hit) begin
            if (!out_full) begin
              used_count <= used_count + CW'(1);
              state <= S_IDLE;
            end
          end else if (last_probe) begin
            if (!out_full) state <= S_IDLE;
          end else begin
            idx <= idx + AW'(1);
            state <= S_SCAN;
          end
        end
        S_RLS: state <= S_RLS_CHK;
        S_RLS_CHK: begin
          // Find the list position of the released slot.
          if (ul_rdata == sid_idx || li + CW'(1) >= used_count) begin
            rel_pos <= AW'(li);
            state <= S_RLS_LAST;
          end else begin
            li <= li + CW'(1);
            state <= S_RLS;
          end
        end
        S_RLS_LAST: state <= S_RLS_MOVE;
        S_RLS_MOVE: if (!out_full) begin
          used_count <= used_count - CW'(1);
          state <= S_IDLE;
        end
        S_LA: state <= S_LAW;
        S_LAW: begin
          a_slot <= ul_rdata;
          state <= S_LAH;
        end
        S_LAH: begin
          a_word <= sm_rdata;
          mask <= '0;
          any <= 1'b0;
          lj <= '0;
          if (r_act) begin
            state <= S_LB;
          end else if (li + CW'(1) == used_count) begin
            state <= S_DONE;
          end else begin
            li <= li + CW'(1);
            state <= S_LA;
          end
        end
        S_LB: begin
          // A slot is not compared with itself.
          if (lj == li) begin
            if (lj + CW'(1) == used_count) state <= S_REC;
            else lj <= lj + CW'(1);
          end else begin
            state <= S_LBW;
          end
        end
        S_LBW: begin
          b_slot <= ul_rdata;
          state <= S_CMP;
        end
        S_CMP: begin
          b_act <= r_act;
          state <= S_PAIR;
        end
        S_PAIR: begin
          if (b_act && hit) begin
            any <= 1'b1;
            if (b_in_mask) mask[4'(b_slot)] <= 1'b1;
          end
          if (lj + CW'(1) == used_count) begin
            state <= S_REC;
          end else begin
            lj <= lj + CW'(1);
            state <= S_LB;
          end
        end
        S_REC: if (rec_go) begin
          if (any) begin
            if (hits != 5'd31) hits <= hits + 5'd1;
            if (!rec_cap) nrec <= nrec + 5'd1;
          end
          if (li + CW'(1) == used_count) begin
            state <= S_DONE;
          end else begin
            li <= li + CW'(1);
            state <= S_LA;
          end
        end
        S_DONE: if (!out_full) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
      res <= '0;
    end else if (emit) begin
      res <= res_next;
      out_full <= 1'b1;
    end else if (out_acc) begin
      out_full <= 1'b0;
    end
  end

  assign out_valid = out_full;
  assign status = res.status;
  assign result_slot = res.slot;
  assign partner_mask = res.mask;
  assign hit_count = res.count;
  assign last = res.last;

  `SCT_ASSERT_IMP(a_no_accept_busy, clk, rst, state != S_IDLE, in_stall, "accept while busy")
  `SCT_ASSERT_IMP(a_count_range, clk, rst, 1'b1, used_count <= CW'(SLOTS), "list overflow")
  `SCT_ASSERT_IMP(a_pair_active, clk, rst, state == S_PAIR, a_act, "inactive slot compared")
  `SCT_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable({status, result_slot, partner_mask, hit_count, last}),
    "output word dropped")
endmodule
`default_nettype wire
